// File: sv/sbd_pkg.sv
// Shared widths, defaults and opcode encodings for the breakpoint distance unit.
package sbd_pkg;

   localparam int OPCODE_W = 2;
   localparam int ID_W     = 10;
   localparam int COUNT_W  = 10;

   localparam int MAX_IDS_DEFAULT     = 1024;
   localparam int MAX_CONTIGS_DEFAULT = 1024;

   typedef enum logic [OPCODE_W-1:0] {
      OP_START = 2'd0,
      OP_LOAD  = 2'd1,
      OP_QUERY = 2'd2
   } opcode_type;

endpackage

// File: sv/scaffold_breakpoint_distance_unit.sv
// Top level: signed breakpoint distance between a query and a reference scaffold.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------------------
//   req     | in        | req_valid/req_stall | opcode, contig_id, orientation, last
//   rsp     | out       | rsp_valid/rsp_stall | mismatch_count
//
// Loads and queries are taken one per cycle while req_stall is low. A query reads
// the contig table at acceptance and is scored in stage 1 against the previous
// query contig; a result goes to the result register once its last query scores.
// Reset and every start transaction run a clearing sweep over every table entry,
// one entry per cycle, during which req_stall stays high.
// A result held by rsp_stall stalls req only once a further last query waits
// to score behind it.
module scaffold_breakpoint_distance_unit #(
   parameter int MAX_IDS     = sbd_pkg::MAX_IDS_DEFAULT,
   parameter int MAX_CONTIGS = sbd_pkg::MAX_CONTIGS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [sbd_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [sbd_pkg::ID_W-1:0]     req_contig_id,
   input  logic                         req_orientation,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [sbd_pkg::COUNT_W-1:0]  rsp_mismatch_count
);
   import sbd_pkg::*;

   localparam int IDX_W  = $clog2(MAX_IDS);
   localparam int POS_W  = $clog2(MAX_CONTIGS);
   localparam int WORD_W = POS_W + 2;   // {valid, position, orientation}
   localparam int EXT_W  = ID_W + IDX_W;

   localparam logic [EXT_W-1:0]   MAX_IDS_EXT = EXT_W'(MAX_IDS);
   localparam logic [IDX_W-1:0]   IDX_LAST    = IDX_W'(MAX_IDS - 1);
   localparam logic [POS_W-1:0]   POS_LAST    = POS_W'(MAX_CONTIGS - 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
      return (c == COUNT_MAX) ? c : c + COUNT_W'(1);
   endfunction

   // Input side decode
   logic             accept, is_start, is_load, is_query;
   logic [EXT_W-1:0] id_ext;
   logic [IDX_W-1:0] id_addr;
   logic             id_in_range;

   assign accept      = req_valid && !req_stall;
   assign is_start    = accept && (req_opcode == OP_START);
   assign is_load     = accept && (req_opcode == OP_LOAD);
   assign is_query    = accept && (req_opcode == OP_QUERY);
   assign id_ext      = {{IDX_W{1'b0}}, req_contig_id};
   assign id_addr     = id_ext[IDX_W-1:0];
   assign id_in_range = id_ext < MAX_IDS_EXT;

   // Table control: clearing sweep, load counter
   logic             clear_ff, clear_in;
   logic [IDX_W-1:0] clear_addr_ff, clear_addr_in;
   logic [POS_W-1:0] load_count_ff, load_count_in;

   // Table RAM
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [WORD_W-1:0] wr_data, rd_data;

   assign wr_en   = clear_ff || (is_load && id_in_range);
   assign wr_addr = clear_ff ? clear_addr_ff : id_addr;
   assign wr_data = clear_ff ? '0 : {1'b1, load_count_ff, req_orientation};

   sbd_ram #(
      .WIDTH(WORD_W),
      .DEPTH(MAX_IDS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (is_query),
      .rd_addr (id_addr),
      .rd_data (rd_data)
   );

   // Scoring stage: carries queries and starts, registered at acceptance
   logic s1_valid_ff, s1_valid_in;
   logic s1_start_ff, s1_start_in;
   logic s1_last_ff, s1_last_in;
   logic s1_orient_ff, s1_orient_in;
   logic s1_in_range_ff, s1_in_range_in;
   logic s1_fire;

   // Previous query contig and running counts
   logic               prev_seen_ff, prev_seen_in;
   logic               prev_valid_ff, prev_valid_in;
   logic [POS_W-1:0]   prev_pos_ff, prev_pos_in;
   logic               prev_ref_ff, prev_ref_in;
   logic               prev_query_ff, prev_query_in;
   logic [COUNT_W-1:0] fwd_count_ff, fwd_count_in;
   logic [COUNT_W-1:0] rev_count_ff, rev_count_in;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // Stage 1 moves on unless it would overwrite a result still held by rsp_stall.
   assign s1_fire   = s1_valid_ff &&
                      (s1_start_ff || !s1_last_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall = clear_ff || (s1_valid_ff && !s1_fire);

   // Lookup fields as read from the table
   logic             hit;
   logic [POS_W-1:0] hit_pos;
   logic             hit_orient;
   logic             orient_bad, fwd_bad, rev_bad;
   logic [COUNT_W-1:0] fwd_next, rev_next;

   assign hit        = s1_in_range_ff && rd_data[WORD_W-1];
   assign hit_pos    = rd_data[WORD_W-2:1];
   assign hit_orient = rd_data[0];
   assign orient_bad = (prev_ref_ff ^ hit_orient) != (prev_query_ff ^ s1_orient_ff);
   // An absent id on either side breaks the pair for both directions.
   assign fwd_bad    = !prev_valid_ff || !hit || (prev_pos_ff > hit_pos) || orient_bad;
   assign rev_bad    = !prev_valid_ff || !hit || (prev_pos_ff < hit_pos) || orient_bad;
   assign fwd_next   = (prev_seen_ff && fwd_bad) ? sat_inc(fwd_count_ff) : fwd_count_ff;
   assign rev_next   = (prev_seen_ff && rev_bad) ? sat_inc(rev_count_ff) : rev_count_ff;

   always_comb begin
      // Clearing sweep and load position
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      load_count_in = load_count_ff;
      if (is_start) begin
         clear_in      = 1'b1;
         clear_addr_in = '0;
         load_count_in = '0;
      end else begin
         if (clear_ff) begin
            clear_addr_in = clear_addr_ff + IDX_W'(1);
            if (clear_addr_ff == IDX_LAST) begin
               clear_in = 1'b0;
            end
         end
         if (is_load && (load_count_ff != POS_LAST)) begin
            load_count_in = load_count_ff + POS_W'(1);
         end
      end

      // Stage 1 load: only starts and queries travel on
      s1_valid_in    = s1_valid_ff && !s1_fire;
      s1_start_in    = s1_start_ff;
      s1_last_in     = s1_last_ff;
      s1_orient_in   = s1_orient_ff;
      s1_in_range_in = s1_in_range_ff;
      if (accept) begin
         s1_valid_in    = is_start || is_query;
         s1_start_in    = is_start;
         s1_last_in     = req_last;
         s1_orient_in   = req_orientation;
         s1_in_range_in = id_in_range;
      end

      // Scoring
      prev_seen_in  = prev_seen_ff;
      prev_valid_in = prev_valid_ff;
      prev_pos_in   = prev_pos_ff;
      prev_ref_in   = prev_ref_ff;
      prev_query_in = prev_query_ff;
      fwd_count_in  = fwd_count_ff;
      rev_count_in  = rev_count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_count_in  = rsp_count_ff;
      if (s1_fire) begin
         if (s1_start_ff) begin
            prev_seen_in = 1'b0;
            fwd_count_in = '0;
            rev_count_in = '0;
         end else if (s1_last_ff) begin
            // Emit the smaller count, then drop the query state; keep the table.
            rsp_valid_in = 1'b1;
            rsp_count_in = (fwd_next < rev_next) ? fwd_next : rev_next;
            prev_seen_in = 1'b0;
            fwd_count_in = '0;
            rev_count_in = '0;
         end else begin
            prev_seen_in  = 1'b1;
            prev_valid_in = hit;
            prev_pos_in   = hit_pos;
            prev_ref_in   = hit_orient;
            prev_query_in = s1_orient_ff;
            fwd_count_in  = fwd_next;
            rev_count_in  = rev_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         load_count_ff <= '0;
         s1_valid_ff   <= 1'b0;
         prev_seen_ff  <= 1'b0;
         fwd_count_ff  <= '0;
         rev_count_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
         load_count_ff <= load_count_in;
         s1_valid_ff   <= s1_valid_in;
         prev_seen_ff  <= prev_seen_in;
         fwd_count_ff  <= fwd_count_in;
         rev_count_ff  <= rev_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      s1_start_ff    <= s1_start_in;
      s1_last_ff     <= s1_last_in;
      s1_orient_ff   <= s1_orient_in;
      s1_in_range_ff <= s1_in_range_in;
      prev_valid_ff  <= prev_valid_in;
      prev_pos_ff    <= prev_pos_in;
      prev_ref_ff    <= prev_ref_in;
      prev_query_ff  <= prev_query_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mismatch_count = rsp_count_ff;

endmodule

// File: sv/sbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/sbd_checker.sv
// Port-level checks for the breakpoint distance unit, bound to the top level.
module sbd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic [sbd_pkg::OPCODE_W-1:0] req_opcode,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [sbd_pkg::COUNT_W-1:0]  rsp_mismatch_count
);
   import sbd_pkg::*;

   // A held result keeps its count.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mismatch_count))
      else $error("result changed while stalled");

   // No result right after reset.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Reset starts the table clearing sweep.
   a_reset_sweep: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("req taken during post-reset sweep");

   // A start transaction starts the clearing sweep.
   a_start_sweep: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_opcode == OP_START) |=> req_stall)
      else $error("req taken right after start");

endmodule

bind scaffold_breakpoint_distance_unit sbd_checker u_sbd_checker (.*);
